// File: rtl/stwc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stwc_pkg: shared types and constants for the shard table
// Record store geometry, operation and status codes, channel payloads and
// the control/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package stwc_pkg;

    // Table geometry (the entry_count field width is tied to this depth)
    localparam int ENTRIES  = 16;
    localparam int IDX_W    = $clog2(ENTRIES);
    localparam int COUNT_W  = $clog2(ENTRIES + 1);

    localparam int KEY_W    = 64;
    localparam int SIZE_W   = 32;
    localparam int CHECK_W  = 32;
    localparam int BYTES_W  = 48;

    // APB port geometry: registers at byte address 8*i
    localparam int PADDR_W  = 4;
    localparam int PDATA_W  = 64;

    typedef enum logic [1:0] {
        KIND_STORE  = 2'd0,
        KIND_READ   = 2'd1,
        KIND_DELETE = 2'd2,
        KIND_QUERY  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        STAT_OK          = 3'd0,
        STAT_UNAVAILABLE = 3'd1,
        STAT_CAPACITY    = 3'd2,
        STAT_EXISTS      = 3'd3,
        STAT_NOT_FOUND   = 3'd4,
        STAT_FULL        = 3'd5
    } t_status;

    // Register index, taken from paddr[3]
    typedef enum logic {
        REG_CAPACITY = 1'b0,
        REG_ONLINE   = 1'b1
    } t_reg_idx;

    typedef enum logic {
        S_IDLE   = 1'b0,
        S_COMMIT = 1'b1
    } t_state;

    typedef struct packed {
        t_kind               kind;
        logic [KEY_W-1:0]    shard_key;
        logic [SIZE_W-1:0]   shard_size;
        logic [CHECK_W-1:0]  shard_checksum;
    } t_req;

    typedef struct packed {
        t_status             status;
        logic                found;
        logic [SIZE_W-1:0]   stored_size;
        logic [CHECK_W-1:0]  stored_checksum;
        logic [BYTES_W-1:0]  used_bytes;
        logic [COUNT_W-1:0]  entry_count;
    } t_rsp;

    typedef struct packed {
        logic [BYTES_W-1:0]  capacity_bytes;
        logic                node_online;
    } t_cfg;

    typedef struct packed {
        logic capture;   // latch the item and its lookup results
        logic commit;    // update the table and load the result
    } t_ctl_cmd;

    typedef struct packed {
        logic out_room;  // result register can take a new result
    } t_ctl_stat;

endpackage

// File: rtl/stwc_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stwc_cfg: configuration register file
// APB-style slave holding the byte capacity and the online flag.
// ----------------------------------------------------------------------------
module stwc_cfg
    import stwc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output t_cfg               o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[3]);
    assign w_wr   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (w_wr) begin
            case (w_idx)
                REG_CAPACITY: r_cfg.capacity_bytes <= pwdata[BYTES_W-1:0];
                REG_ONLINE:   r_cfg.node_online    <= pwdata[0];
                default:      r_cfg                <= r_cfg;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_CAPACITY: prdata = {{(PDATA_W-BYTES_W){1'b0}}, r_cfg.capacity_bytes};
            REG_ONLINE:   prdata = {{(PDATA_W-1){1'b0}}, r_cfg.node_online};
            default:      prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// File: rtl/stwc_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stwc_ctrl: operation sequencer
// Two-state controller: take an item, then commit it once the result
// register has room.
// ----------------------------------------------------------------------------
module stwc_ctrl
    import stwc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_ctl_stat i_stat,
    output t_ctl_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_in_stall  = 1'b0;
                o_cmd.capture = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                // hold until the previous result has left
                if (i_stat.out_room) begin
                    o_cmd.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/stwc_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stwc_dp: record table datapath
// Record registers, parallel key match, free-slot search, byte and record
// counters, and the result register.
// ----------------------------------------------------------------------------
module stwc_dp
    import stwc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_req      i_req,
    input  t_cfg      i_cfg,
    input  t_ctl_cmd  i_cmd,
    output t_ctl_stat o_stat,
    input  logic      i_out_stall,
    output logic      o_out_valid,
    output t_rsp      o_out_item
);

    // record table
    logic [ENTRIES-1:0]  r_valid;
    logic [KEY_W-1:0]    r_key   [ENTRIES];
    logic [SIZE_W-1:0]   r_size  [ENTRIES];
    logic [CHECK_W-1:0]  r_check [ENTRIES];
    logic [BYTES_W-1:0]  r_used;
    logic [COUNT_W-1:0]  r_count;

    // captured item and lookup results
    t_req                r_req;
    logic                r_hit;
    logic [IDX_W-1:0]    r_hit_idx;
    logic                r_has_free;
    logic [IDX_W-1:0]    r_free_idx;
    logic                r_cap_over;

    // result register
    logic                r_out_valid;
    t_rsp                r_out_item;

    logic                w_hit;
    logic [IDX_W-1:0]    w_hit_idx;
    logic                w_has_free;
    logic [IDX_W-1:0]    w_free_idx;
    logic                w_cap_over;

    t_status             n_status;
    logic                n_store;
    logic                n_delete;
    logic                n_rd;
    logic [BYTES_W-1:0]  n_used;
    logic [COUNT_W-1:0]  n_count;
    logic [SIZE_W-1:0]   w_hit_size;

    // lowest matching slot and lowest free slot
    always_comb begin
        w_hit      = 1'b0;
        w_hit_idx  = '0;
        w_has_free = 1'b0;
        w_free_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--) begin
            if (r_valid[i] && (r_key[i] == i_req.shard_key)) begin
                w_hit     = 1'b1;
                w_hit_idx = IDX_W'(i);
            end
            if (!r_valid[i]) begin
                w_has_free = 1'b1;
                w_free_idx = IDX_W'(i);
            end
        end
    end

    assign w_cap_over = ({1'b0, r_used} + {{(BYTES_W-SIZE_W+1){1'b0}}, i_req.shard_size})
                        > {1'b0, i_cfg.capacity_bytes};

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req      <= i_req;
            r_hit      <= w_hit;
            r_hit_idx  <= w_hit_idx;
            r_has_free <= w_has_free;
            r_free_idx <= w_free_idx;
            r_cap_over <= w_cap_over;
        end
    end

    assign w_hit_size = r_size[r_hit_idx];

    // operation decision
    always_comb begin
        n_status = STAT_OK;
        n_store  = 1'b0;
        n_delete = 1'b0;
        n_rd     = 1'b0;
        n_used   = r_used;
        n_count  = r_count;
        case (r_req.kind)
            KIND_STORE: begin
                if (!i_cfg.node_online) begin
                    n_status = STAT_UNAVAILABLE;
                end else if (r_cap_over) begin
                    n_status = STAT_CAPACITY;
                end else if (r_hit) begin
                    n_status = STAT_EXISTS;
                end else if (!r_has_free) begin
                    n_status = STAT_FULL;
                end else begin
                    n_store = 1'b1;
                    n_used  = r_used + {{(BYTES_W-SIZE_W){1'b0}}, r_req.shard_size};
                    n_count = r_count + COUNT_W'(1);
                end
            end
            KIND_READ: begin
                if (!i_cfg.node_online) begin
                    n_status = STAT_UNAVAILABLE;
                end else if (!r_hit) begin
                    n_status = STAT_NOT_FOUND;
                end else begin
                    n_rd = 1'b1;
                end
            end
            KIND_DELETE: begin
                if (!r_hit) begin
                    n_status = STAT_NOT_FOUND;
                end else begin
                    n_delete = 1'b1;
                    // saturate at zero
                    if (r_used >= {{(BYTES_W-SIZE_W){1'b0}}, w_hit_size}) begin
                        n_used = r_used - {{(BYTES_W-SIZE_W){1'b0}}, w_hit_size};
                    end else begin
                        n_used = '0;
                    end
                    if (r_count != '0) begin
                        n_count = r_count - COUNT_W'(1);
                    end
                end
            end
            KIND_QUERY: begin
                n_status = STAT_OK;
            end
            default: begin
                n_status = STAT_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_used  <= '0;
            r_count <= '0;
        end else if (i_cmd.commit) begin
            r_used  <= n_used;
            r_count <= n_count;
            if (n_store) begin
                r_valid[r_free_idx] <= 1'b1;
            end
            if (n_delete) begin
                r_valid[r_hit_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && n_store) begin
            r_key[r_free_idx]   <= r_req.shard_key;
            r_size[r_free_idx]  <= r_req.shard_size;
            r_check[r_free_idx] <= r_req.shard_checksum;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_item.status          <= n_status;
            r_out_item.found           <= r_hit;
            r_out_item.stored_size     <= n_rd ? w_hit_size : '0;
            r_out_item.stored_checksum <= n_rd ? r_check[r_hit_idx] : '0;
            r_out_item.used_bytes      <= n_used;
            r_out_item.entry_count     <= n_count;
        end
    end

    assign o_stat.out_room = !r_out_valid || !i_out_stall;
    assign o_out_valid     = r_out_valid;
    assign o_out_item      = r_out_item;

endmodule

// File: rtl/shard_table_with_capacity_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shard_table_with_capacity_core: keyed shard metadata table with byte limit
// Holds up to ENTRIES records (key, size, checksum) and a running byte total
// checked against a programmable capacity.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_item) carries one operation
//   per transaction: store, read, delete or presence query. Output channel
//   (o_out_valid / i_out_stall / o_out_item) returns exactly one result per
//   operation, in order.
//   Sequencing: the two-state sequencer captures an accepted transaction
//   with its lookup results (parallel key match against all records), then
//   commits it (table and counter update, result register load); the input
//   stalls until that commit, so a new operation waits for the previous one.
//   A pending result in the output register does not block acceptance of the
//   next transaction; the commit of that next one waits until the output
//   register drains, and the input stalls meanwhile.
//   Reset (i_rst_n low, synchronous) clears all valid marks, the byte total,
//   the record count, capacity and the online flag. No clearing pass is
//   needed; the block accepts transactions as soon as reset is released.
//   Configuration: APB write to address 0 (capacity, 48 bits) or 8 (online
//   flag, bit 0); write only while no transaction is in flight.
// ----------------------------------------------------------------------------
module shard_table_with_capacity_core
    import stwc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,

    // APB configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,

    // operation channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  t_req               i_in_item,

    // result channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output t_rsp               o_out_item
);

    t_cfg      w_cfg;
    t_ctl_cmd  w_cmd;
    t_ctl_stat w_stat;

    // capacity and online flag
    stwc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // capture on accept, commit once the result register has room
    stwc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // record table, lookup, counters and result register
    stwc_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_in_item),
        .i_cfg       (w_cfg),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule

// File: verif/shard_table_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shard_table_checker: result predictor and scoreboard for the shard table
// Follows register writes and accepted operations, keeps its own copy of the
// record table, and compares every accepted result with the oldest expected.
// ----------------------------------------------------------------------------
module shard_table_checker
    import stwc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,

    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic               i_pready,
    input  logic [PADDR_W-1:0] i_paddr,
    input  logic [PDATA_W-1:0] i_pwdata,

    input  logic               i_in_valid,
    input  logic               i_in_stall,
    input  t_req               i_in_item,

    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  t_rsp               i_out_item,

    output int                 o_mismatches,
    output int                 o_outstanding
);

    logic                slot_used  [ENTRIES];
    logic [KEY_W-1:0]    slot_key   [ENTRIES];
    logic [SIZE_W-1:0]   slot_size  [ENTRIES];
    logic [CHECK_W-1:0]  slot_check [ENTRIES];
    logic [BYTES_W-1:0]  bytes_used;
    logic [COUNT_W-1:0]  records;
    logic [BYTES_W-1:0]  capacity;
    logic                online;

    t_rsp                awaited_results[$];
    int                  mismatches = 0;

    // Apply one operation to the table copy and return the result it yields.
    function automatic t_rsp apply_operation(t_req op);
        int                 hit;
        int                 free_slot;
        logic [BYTES_W:0]   total;
        logic [BYTES_W-1:0] freed;
        t_rsp               rsp;
        hit       = -1;
        free_slot = -1;
        for (int s = ENTRIES - 1; s >= 0; s--) begin
            if (slot_used[s] && slot_key[s] == op.shard_key) hit = s;
            if (!slot_used[s]) free_slot = s;
        end
        rsp        = '0;
        rsp.status = STAT_OK;
        rsp.found  = (hit >= 0);
        total      = {1'b0, bytes_used} + {{(BYTES_W-SIZE_W+1){1'b0}}, op.shard_size};
        case (op.kind)
            KIND_STORE: begin
                if (!online) rsp.status = STAT_UNAVAILABLE;
                else if (total > {1'b0, capacity}) rsp.status = STAT_CAPACITY;
                else if (hit >= 0) rsp.status = STAT_EXISTS;
                else if (free_slot < 0) rsp.status = STAT_FULL;
                else begin
                    slot_used[free_slot]  = 1'b1;
                    slot_key[free_slot]   = op.shard_key;
                    slot_size[free_slot]  = op.shard_size;
                    slot_check[free_slot] = op.shard_checksum;
                    bytes_used            = total[BYTES_W-1:0];
                    records               = records + COUNT_W'(1);
                end
            end
            KIND_READ: begin
                if (!online) rsp.status = STAT_UNAVAILABLE;
                else if (hit < 0) rsp.status = STAT_NOT_FOUND;
                else begin
                    rsp.stored_size     = slot_size[hit];
                    rsp.stored_checksum = slot_check[hit];
                end
            end
            KIND_DELETE: begin
                if (hit < 0) rsp.status = STAT_NOT_FOUND;
                else begin
                    // saturate at zero
                    freed      = {{(BYTES_W-SIZE_W){1'b0}}, slot_size[hit]};
                    bytes_used = (bytes_used >= freed) ? bytes_used - freed : '0;
                    slot_used[hit] = 1'b0;
                    if (records != '0) records = records - COUNT_W'(1);
                end
            end
            default: ;
        endcase
        rsp.used_bytes  = bytes_used;
        rsp.entry_count = records;
        return rsp;
    endfunction

    always @(posedge i_clk) begin
        t_rsp want;
        t_rsp got;
        if (!i_rst_n) begin
            for (int s = 0; s < ENTRIES; s++) begin
                slot_used[s]  = 1'b0;
                slot_key[s]   = '0;
                slot_size[s]  = '0;
                slot_check[s] = '0;
            end
            bytes_used = '0;
            records    = '0;
            capacity   = '0;
            online     = 1'b0;
            awaited_results.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (t_reg_idx'(i_paddr[PADDR_W-1]) == REG_CAPACITY)
                    capacity = i_pwdata[BYTES_W-1:0];
                else
                    online = i_pwdata[0];
            end
            // check the result first: it belongs to an earlier transaction
            if (i_out_valid && !i_out_stall) begin
                got = i_out_item;
                if (awaited_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected result status=%0d used=%h count=%0d",
                                 $time, got.status, got.used_bytes, got.entry_count);
                end else begin
                    want = awaited_results.pop_front();
                    if (got.status !== want.status || got.found !== want.found ||
                        got.stored_size !== want.stored_size ||
                        got.stored_checksum !== want.stored_checksum ||
                        got.used_bytes !== want.used_bytes ||
                        got.entry_count !== want.entry_count) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display({"%0t: expected status=%0d found=%0b size=%h",
                                      " check=%h used=%h count=%0d"},
                                     $time, want.status, want.found, want.stored_size,
                                     want.stored_checksum, want.used_bytes, want.entry_count);
                            $display({"%0t:   actual status=%0d found=%0b size=%h",
                                      " check=%h used=%h count=%0d"},
                                     $time, got.status, got.found, got.stored_size,
                                     got.stored_checksum, got.used_bytes, got.entry_count);
                        end
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                awaited_results = {awaited_results, apply_operation(i_in_item)};
        end
        o_mismatches  <= mismatches;
        o_outstanding <= awaited_results.size();
    end

endmodule

// File: verif/tb_shard_table_with_capacity_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_shard_table_with_capacity_core: stimulus and verdict for the shard table
// Drives a directed sequence over offline, capacity, duplicate and full-table
// cases, then phases of random operations over a small key pool under
// several capacity and online settings, with random gaps and output stalls.
// ----------------------------------------------------------------------------
module tb_shard_table_with_capacity_core
    import stwc_pkg::*;
;

    localparam int                 POOL_KEYS = 24;
    localparam int                 PHASES    = 8;
    localparam int                 PHASE_OPS = 105;
    localparam logic [BYTES_W-1:0] CAP_MAX   = '1;

    logic               i_clk;
    logic               i_rst_n;

    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    logic               in_valid;
    logic               in_stall;
    t_req               in_item;
    logic               out_valid;
    logic               out_stall;
    t_rsp               out_item;

    int                 mismatches;
    int                 outstanding;

    // Quiet phases run back to back: no input gaps, no output stalls.
    logic               quiet = 1'b0;
    logic [KEY_W-1:0]   key_pool [POOL_KEYS];

    shard_table_with_capacity_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (out_item)
    );

    // Predict and compare beside the block; hand back the failure count.
    shard_table_checker i_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_pready      (pready),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .i_in_valid    (in_valid),
        .i_in_stall    (in_stall),
        .i_in_item     (in_item),
        .i_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .i_out_item    (out_item),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 2);
        if (r < 97) return $urandom_range(3, 6);
        return $urandom_range(10, 30);
    endfunction

    // Output stall: hold each level for a random run of cycles, so stalls
    // land on every phase of the lookup/commit sequence.
    initial begin
        int run;
        run       = 0;
        out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (quiet) begin
                out_stall = 1'b0;
                run       = 0;
            end else if (run > 0) begin
                run--;
            end else if ($urandom_range(0, 99) < 30) begin
                out_stall = 1'b1;
                run       = pick_gap();
            end else begin
                out_stall = 1'b0;
                run       = $urandom_range(0, 4);
            end
        end
    end

    // APB write: setup cycle, then access cycle until pready.
    task automatic write_reg(t_reg_idx idx, logic [PDATA_W-1:0] value);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 3'b000};
        pwdata  = value;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Present one operation after a random gap and hold it until accepted.
    task automatic send_op(t_kind kind, logic [KEY_W-1:0] key,
                           logic [SIZE_W-1:0] size, logic [CHECK_W-1:0] check);
        int gap;
        gap = quiet ? 0 : pick_gap();
        @(negedge i_clk);
        if (gap != 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid               = 1'b1;
        in_item.kind           = kind;
        in_item.shard_key      = key;
        in_item.shard_size     = size;
        in_item.shard_checksum = check;
        do @(posedge i_clk); while (in_stall);
    endtask

    // Drop valid and wait until every expected result has come back.
    task automatic drain();
        @(negedge i_clk);
        in_valid = 1'b0;
        while (outstanding != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Random operation over the key pool; a few keys are fresh so that
    // misses stay common even when the pool is mostly stored.
    task automatic random_op(logic small_sizes);
        int                 r;
        t_kind              kind;
        logic [KEY_W-1:0]   key;
        logic [SIZE_W-1:0]  size;
        r = $urandom_range(0, 99);
        if (r < 35)      kind = KIND_STORE;
        else if (r < 55) kind = KIND_READ;
        else if (r < 85) kind = KIND_DELETE;
        else             kind = KIND_QUERY;
        if ($urandom_range(0, 9) == 0) key = {$urandom, $urandom};
        else key = key_pool[$urandom_range(0, POOL_KEYS - 1)];
        if (small_sizes || $urandom_range(0, 3) != 0) size = $urandom_range(0, 2500);
        else size = $urandom;
        send_op(kind, key, size, $urandom);
    endtask

    initial begin
        logic [BYTES_W-1:0] cap;
        logic               small_sizes;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        in_valid = 1'b0;
        in_item  = '0;
        i_rst_n  = 1'b0;
        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int k = 2; k < POOL_KEYS; k++) key_pool[k] = {$urandom, $urandom};
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Offline after reset: store and read are refused, delete and
        // presence query still answer.
        send_op(KIND_STORE,  key_pool[23], 32'd5, 32'h1234_5678);
        send_op(KIND_READ,   key_pool[23], '0, '0);
        send_op(KIND_DELETE, key_pool[23], '0, '0);
        send_op(KIND_QUERY,  key_pool[23], '0, '0);
        drain();

        // Online with zero capacity: a zero-size store just fits, one byte
        // does not.
        write_reg(REG_ONLINE, 64'd1);
        send_op(KIND_STORE, key_pool[0],  '0, '0);
        send_op(KIND_STORE, key_pool[23], 32'd1, '1);
        drain();

        // Full capacity: extreme key, size and checksum; duplicate store,
        // read, query, delete and misses after the delete.
        write_reg(REG_CAPACITY, 64'(CAP_MAX));
        send_op(KIND_STORE,  key_pool[1], '1, '1);
        send_op(KIND_STORE,  key_pool[1], '0, '0);
        send_op(KIND_READ,   key_pool[1], '0, '0);
        send_op(KIND_QUERY,  key_pool[1], '0, '0);
        send_op(KIND_DELETE, key_pool[1], '0, '0);
        send_op(KIND_DELETE, key_pool[1], '0, '0);
        send_op(KIND_READ,   key_pool[1], '0, '0);

        // Fill every slot, then a new key hits the full table while a
        // present key still reports the duplicate first.
        for (int k = 2; k <= 16; k++)
            send_op(KIND_STORE, key_pool[k], $urandom_range(0, 2500), $urandom);
        send_op(KIND_STORE, key_pool[20], 32'd7, $urandom);
        send_op(KIND_STORE, key_pool[0],  '0, '0);
        drain();

        // Capacity lowered below usage: even a zero-size store is refused.
        write_reg(REG_CAPACITY, 64'd1);
        send_op(KIND_STORE, key_pool[21], '0, $urandom);
        drain();

        // Random phases, each under its own capacity and online setting.
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0, 4, 7: begin
                    cap         = CAP_MAX;
                    small_sizes = 1'b0;
                end
                2: begin
                    cap         = BYTES_W'({$urandom, $urandom});
                    small_sizes = 1'b0;
                end
                6: begin
                    cap         = '0;
                    small_sizes = 1'b1;
                end
                default: begin
                    cap         = BYTES_W'($urandom_range(2000, 40000));
                    small_sizes = 1'b1;
                end
            endcase
            quiet = (p == 3 || p == 7);
            write_reg(REG_CAPACITY, 64'(cap));
            write_reg(REG_ONLINE, (p == 5) ? 64'd0 : 64'd1);
            repeat (PHASE_OPS) random_op(small_sizes);
            drain();
        end

        // drain() already waited out the pipeline; give the verdict.
        if (mismatches == 0 && outstanding == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Hard stop in case a handshake never completes.
    initial begin
        #10_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
